/* sv/lpbf_pkg.sv */
// Package for the LED PWM dimmer with blink and fade.
// Holds action and mode codes, register map, config and item structs.
// No dependencies.
package lpbf_pkg;

	// Command codes carried in the action field
	typedef enum logic [2:0] {
		ACT_TICK     = 3'd0,
		ACT_SET      = 3'd1,
		ACT_STEP_UP  = 3'd2,
		ACT_STEP_DN  = 3'd3,
		ACT_BLINK    = 3'd4,
		ACT_FADE     = 3'd5,
		ACT_STOP     = 3'd6
	} action_t;

	// Mode reported with each result
	localparam logic [1:0] MODE_STEADY = 2'd0;
	localparam logic [1:0] MODE_BLINK  = 2'd1;
	localparam logic [1:0] MODE_FADE   = 2'd2;

	// Register map, byte address = 4 * index
	localparam int ADDR_BITS = 5;
	localparam int DATA_BITS = 32;

	typedef enum logic [2:0] {
		REG_BLINK_ON_LEVEL  = 3'd0,
		REG_BLINK_OFF_LEVEL = 3'd1,
		REG_BLINK_ON_TICKS  = 3'd2,
		REG_BLINK_OFF_TICKS = 3'd3,
		REG_FADE_STEP_TICKS = 3'd4
	} reg_idx_t;

	// Brightness and timer widths of the register and item fields
	localparam int BRIGHT_BITS = 8;
	localparam int TICK_BITS   = 16;

	typedef struct packed {
		logic [BRIGHT_BITS-1:0] blink_on_level;
		logic [BRIGHT_BITS-1:0] blink_off_level;
		logic [TICK_BITS-1:0]   blink_on_ticks;
		logic [TICK_BITS-1:0]   blink_off_ticks;
		logic [TICK_BITS-1:0]   fade_step_ticks;
	} cfg_t;

	typedef struct packed {
		logic [2:0]             action;
		logic [BRIGHT_BITS-1:0] brightness;
		logic [BRIGHT_BITS-1:0] end_brightness;
		logic                   restore_end;
		logic                   endless;
		logic [TICK_BITS-1:0]   duration;
	} item_t;

endpackage

/* sv/lpbf_regs.sv */
// APB-style configuration register file for the LED dimmer.
// Depends on lpbf_pkg (cfg_t, register indexes, address and data widths).
module lpbf_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [lpbf_pkg::ADDR_BITS-1:0] paddr,
	input  logic [lpbf_pkg::DATA_BITS-1:0] pwdata,
	output logic [lpbf_pkg::DATA_BITS-1:0] prdata,
	output logic                           pready,
	output lpbf_pkg::cfg_t                 cfg
);

	lpbf_pkg::cfg_t cfg_q;
	logic [2:0]     idx;
	logic           wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[lpbf_pkg::ADDR_BITS-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	// Register writes in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.blink_on_level  <= '0;
			cfg_q.blink_off_level <= '0;
			cfg_q.blink_on_ticks  <= lpbf_pkg::TICK_BITS'(1);
			cfg_q.blink_off_ticks <= lpbf_pkg::TICK_BITS'(1);
			cfg_q.fade_step_ticks <= lpbf_pkg::TICK_BITS'(1);
		end else if (wr_en) begin
			case (idx)
				lpbf_pkg::REG_BLINK_ON_LEVEL:
					cfg_q.blink_on_level <= pwdata[lpbf_pkg::BRIGHT_BITS-1:0];
				lpbf_pkg::REG_BLINK_OFF_LEVEL:
					cfg_q.blink_off_level <= pwdata[lpbf_pkg::BRIGHT_BITS-1:0];
				lpbf_pkg::REG_BLINK_ON_TICKS:
					cfg_q.blink_on_ticks <= pwdata[lpbf_pkg::TICK_BITS-1:0];
				lpbf_pkg::REG_BLINK_OFF_TICKS:
					cfg_q.blink_off_ticks <= pwdata[lpbf_pkg::TICK_BITS-1:0];
				lpbf_pkg::REG_FADE_STEP_TICKS:
					cfg_q.fade_step_ticks <= pwdata[lpbf_pkg::TICK_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Read mux, unmapped addresses read zero
	always_comb begin
		case (idx)
			lpbf_pkg::REG_BLINK_ON_LEVEL:
				prdata = lpbf_pkg::DATA_BITS'(cfg_q.blink_on_level);
			lpbf_pkg::REG_BLINK_OFF_LEVEL:
				prdata = lpbf_pkg::DATA_BITS'(cfg_q.blink_off_level);
			lpbf_pkg::REG_BLINK_ON_TICKS:
				prdata = lpbf_pkg::DATA_BITS'(cfg_q.blink_on_ticks);
			lpbf_pkg::REG_BLINK_OFF_TICKS:
				prdata = lpbf_pkg::DATA_BITS'(cfg_q.blink_off_ticks);
			lpbf_pkg::REG_FADE_STEP_TICKS:
				prdata = lpbf_pkg::DATA_BITS'(cfg_q.fade_step_ticks);
			default:
				prdata = '0;
		endcase
	end

endmodule

/* sv/lpbf_core.sv */
// State registers and single-step update logic of the LED dimmer.
// Depends on lpbf_pkg (item_t, cfg_t, action and mode codes).
module lpbf_core #(
	parameter int LEVEL_BITS = 3,
	parameter int TIMER_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  lpbf_pkg::item_t       item,
	input  lpbf_pkg::cfg_t        cfg,
	output logic                  nxt_led_on,
	output logic [LEVEL_BITS-1:0] nxt_level,
	output logic [1:0]            nxt_mode
);

	localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = {LEVEL_BITS{1'b1}};
	localparam int BRIGHT_SHIFT = lpbf_pkg::BRIGHT_BITS - LEVEL_BITS;

	// top LEVEL_BITS bits of a brightness
	function automatic logic [LEVEL_BITS-1:0] to_level(logic [lpbf_pkg::BRIGHT_BITS-1:0] b);
		return b[lpbf_pkg::BRIGHT_BITS-1 -: LEVEL_BITS];
	endfunction

	// a timer at 0 or 1 expires on this tick
	function automatic logic tmr_done(logic [TIMER_BITS-1:0] w);
		return (w >> 1) == '0;
	endfunction

	// State registers
	logic [LEVEL_BITS-1:0]            level_q, n_level;
	logic                             pin_q, n_pin;
	logic [LEVEL_BITS-1:0]            pwm_wait_q, n_pwm_wait;
	logic                             blink_q, n_blink;
	logic                             phase_on_q, n_phase_on;
	logic [TIMER_BITS-1:0]            blink_wait_q, n_blink_wait;
	logic                             fade_q, n_fade;
	logic                             going_down_q, n_going_down;
	logic [TIMER_BITS-1:0]            fade_wait_q, n_fade_wait;
	logic                             armed_q, n_armed;
	logic [TIMER_BITS-1:0]            stop_wait_q, n_stop_wait;
	logic [lpbf_pkg::BRIGHT_BITS-1:0] end_level_q, n_end_level;

	// Next state for one tick or command
	always_comb begin
		n_level      = level_q;
		n_pin        = pin_q;
		n_pwm_wait   = pwm_wait_q;
		n_blink      = blink_q;
		n_phase_on   = phase_on_q;
		n_blink_wait = blink_wait_q;
		n_fade       = fade_q;
		n_going_down = going_down_q;
		n_fade_wait  = fade_wait_q;
		n_armed      = armed_q;
		n_stop_wait  = stop_wait_q;
		n_end_level  = end_level_q;

		case (item.action)
			lpbf_pkg::ACT_TICK: begin
				// auto stop counts first
				if (n_armed) begin
					if (tmr_done(n_stop_wait)) begin
						n_armed = 1'b0;
						n_blink = 1'b0;
						n_fade  = 1'b0;
						n_level = to_level(n_end_level);
					end else begin
						n_stop_wait = n_stop_wait - 1'b1;
					end
				end
				// blink phase timer
				if (n_blink) begin
					if (tmr_done(n_blink_wait)) begin
						if (n_phase_on) begin
							n_phase_on   = 1'b0;
							n_level      = to_level(cfg.blink_off_level);
							n_blink_wait = TIMER_BITS'(cfg.blink_off_ticks);
						end else begin
							n_phase_on   = 1'b1;
							n_level      = to_level(cfg.blink_on_level);
							n_blink_wait = TIMER_BITS'(cfg.blink_on_ticks);
						end
					end else begin
						n_blink_wait = n_blink_wait - 1'b1;
					end
				end
				// fade step timer, triangle between 0 and max
				if (n_fade) begin
					if (tmr_done(n_fade_wait)) begin
						if (n_going_down)
							n_level = n_level - 1'b1;
						else
							n_level = n_level + 1'b1;
						if (n_level == LEVEL_MAX)
							n_going_down = 1'b1;
						else if (n_level == '0)
							n_going_down = 1'b0;
						n_fade_wait = TIMER_BITS'(cfg.fade_step_ticks);
					end else begin
						n_fade_wait = n_fade_wait - 1'b1;
					end
				end
				// soft PWM decision
				if ((n_pwm_wait >> 1) == '0) begin
					if (n_level == '0) begin
						n_pin      = 1'b0;
						n_pwm_wait = LEVEL_MAX;
					end else if (n_level == LEVEL_MAX) begin
						n_pin      = 1'b1;
						n_pwm_wait = LEVEL_MAX;
					end else begin
						n_pwm_wait = n_pin ? (LEVEL_MAX - n_level) : n_level;
						n_pin      = ~n_pin;
					end
				end else begin
					n_pwm_wait = n_pwm_wait - 1'b1;
				end
			end
			lpbf_pkg::ACT_SET:     n_level = to_level(item.brightness);
			lpbf_pkg::ACT_STEP_UP: n_level = level_q + 1'b1;
			lpbf_pkg::ACT_STEP_DN: n_level = level_q - 1'b1;
			lpbf_pkg::ACT_BLINK, lpbf_pkg::ACT_FADE: begin
				// stop whatever runs, then arm the new end level and auto stop
				n_level = to_level(end_level_q);
				n_end_level = item.restore_end
					? (lpbf_pkg::BRIGHT_BITS'(level_q) << BRIGHT_SHIFT)
					: item.end_brightness;
				n_armed = !item.endless;
				if (!item.endless)
					n_stop_wait = TIMER_BITS'(item.duration);
				if (item.action == lpbf_pkg::ACT_BLINK) begin
					n_blink      = 1'b1;
					n_fade       = 1'b0;
					n_phase_on   = 1'b0;
					n_level      = to_level(cfg.blink_off_level);
					n_blink_wait = TIMER_BITS'(cfg.blink_off_ticks);
				end else begin
					n_blink      = 1'b0;
					n_fade       = 1'b1;
					n_going_down = 1'b0;
					n_level      = '0;
					n_fade_wait  = TIMER_BITS'(cfg.fade_step_ticks);
				end
			end
			lpbf_pkg::ACT_STOP: begin
				n_armed = 1'b0;
				n_blink = 1'b0;
				n_fade  = 1'b0;
				n_level = to_level(end_level_q);
			end
			default: ;
		endcase
	end

	// State update on each transfer through the stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q      <= '0;
			pin_q        <= 1'b0;
			pwm_wait_q   <= '0;
			blink_q      <= 1'b0;
			phase_on_q   <= 1'b0;
			blink_wait_q <= '0;
			fade_q       <= 1'b0;
			going_down_q <= 1'b0;
			fade_wait_q  <= '0;
			armed_q      <= 1'b0;
			stop_wait_q  <= '0;
			end_level_q  <= '0;
		end else if (fire) begin
			level_q      <= n_level;
			pin_q        <= n_pin;
			pwm_wait_q   <= n_pwm_wait;
			blink_q      <= n_blink;
			phase_on_q   <= n_phase_on;
			blink_wait_q <= n_blink_wait;
			fade_q       <= n_fade;
			going_down_q <= n_going_down;
			fade_wait_q  <= n_fade_wait;
			armed_q      <= n_armed;
			stop_wait_q  <= n_stop_wait;
			end_level_q  <= n_end_level;
		end
	end

	// Result fields
	assign nxt_led_on = n_pin;
	assign nxt_level  = n_level;
	assign nxt_mode   = n_blink ? lpbf_pkg::MODE_BLINK
		: (n_fade ? lpbf_pkg::MODE_FADE : lpbf_pkg::MODE_STEADY);

endmodule

/* sv/led_pwm_blink_fade_controller_top.sv */
// Top level of the LED PWM dimmer with blink and breathing fade.
// Depends on lpbf_pkg, lpbf_regs and lpbf_core.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+----------------------------------------
//  in       | in_valid / in_stall     | action brightness end_brightness
//           |                         | restore_end endless duration
//  out      | out_valid / out_stall   | led_on level mode
//  config   | psel penable pwrite     | paddr pwdata prdata, pready tied high
//
// One item per cycle while the result register is empty or taken: input register,
// combinational update logic against the state registers, result register.
// An item waits in the input register until the result register frees. The
// input register holds one item while a result is stalled;
// in_stall rises only when both are occupied and out_stall is high.
// Reset clears the core state, valid flags and config registers to defaults.
module led_pwm_blink_fade_controller_top #(
	parameter int LEVEL_BITS = 3,
	parameter int TIMER_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [2:0]                     action,
	input  logic [7:0]                     brightness,
	input  logic [7:0]                     end_brightness,
	input  logic                           restore_end,
	input  logic                           endless,
	input  logic [15:0]                    duration,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           led_on,
	output logic [LEVEL_BITS-1:0]          level,
	output logic [1:0]                     mode,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [lpbf_pkg::ADDR_BITS-1:0] paddr,
	input  logic [lpbf_pkg::DATA_BITS-1:0] pwdata,
	output logic [lpbf_pkg::DATA_BITS-1:0] prdata,
	output logic                           pready
);

	lpbf_pkg::cfg_t  cfg;
	lpbf_pkg::item_t item_s1;
	logic            valid_s1;
	logic            advance;
	logic            fire;
	logic            nxt_led_on;
	logic [LEVEL_BITS-1:0] nxt_level;
	logic [1:0]      nxt_mode;
	logic            out_valid_q;
	logic            led_on_q;
	logic [LEVEL_BITS-1:0] level_q;
	logic [1:0]      mode_q;

	lpbf_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Handshake: the result register frees when empty or taken
	assign advance  = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.action         <= action;
			item_s1.brightness     <= brightness;
			item_s1.end_brightness <= end_brightness;
			item_s1.restore_end    <= restore_end;
			item_s1.endless        <= endless;
			item_s1.duration       <= duration;
		end
	end

	lpbf_core #(
		.LEVEL_BITS (LEVEL_BITS),
		.TIMER_BITS (TIMER_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.item       (item_s1),
		.cfg        (cfg),
		.nxt_led_on (nxt_led_on),
		.nxt_level  (nxt_level),
		.nxt_mode   (nxt_mode)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			led_on_q <= nxt_led_on;
			level_q  <= nxt_level;
			mode_q   <= nxt_mode;
		end
	end

	assign out_valid = out_valid_q;
	assign led_on    = led_on_q;
	assign level     = level_q;
	assign mode      = mode_q;

endmodule

/* sv/lpbf_checker.sv */
// Port-level assertions for the LED dimmer top level, with its bind.
// Depends on lpbf_pkg (address and data widths).
module lpbf_checker #(
	parameter int LEVEL_BITS = 3
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic                           led_on,
	input logic [LEVEL_BITS-1:0]          level,
	input logic [1:0]                     mode,
	input logic                           psel,
	input logic                           penable,
	input logic                           pwrite,
	input logic [lpbf_pkg::ADDR_BITS-1:0] paddr,
	input logic [lpbf_pkg::DATA_BITS-1:0] pwdata,
	input logic [lpbf_pkg::DATA_BITS-1:0] prdata
);

	// A stalled result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(led_on) && $stable(level)
			&& $stable(mode))
		else $error("result changed while stalled");

	// Input is only stalled when the output side is backed up
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && out_stall) |-> !in_stall)
		else $error("input stalled without output backpressure");

	// A transfer in, with out_stall low after it, leads to a valid result
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 !out_stall |=> out_valid)
		else $error("result missing after transfer");

	// A register write reads back in the next cycle
	a_readback: assert property (@(posedge clk) disable iff (!arst_n)
		$past(psel && penable && pwrite) && psel && !pwrite
			&& paddr == $past(paddr) && paddr[lpbf_pkg::ADDR_BITS-1:2] <= 3'd4
			|-> prdata[7:0] == $past(pwdata[7:0]))
		else $error("register read back mismatch");

endmodule

bind led_pwm_blink_fade_controller_top lpbf_checker #(.LEVEL_BITS(LEVEL_BITS)) u_lpbf_checker (.*);

/* sim/led_pwm_blink_fade_controller_top_tb.sv */
// Testbench for led_pwm_blink_fade_controller_top: directed and random items.
// A scoreboard class predicts led_on, level and mode for each transfer.
// Depends on lpbf_pkg and the top-level RTL.
`timescale 1ns / 1ps

module led_pwm_blink_fade_controller_top_tb;

	localparam logic [2:0] LEVEL_MAX = 3'd7;

	// Expected result of one item
	typedef struct {
		logic       led_on;
		logic [2:0] level;
		logic [1:0] mode;
	} led_result_t;

	// Dimmer predictor plus the queue of results still to arrive
	class dimmer_scoreboard;
		lpbf_pkg::cfg_t regs;
		logic [2:0]  dim_level;
		logic        pin;
		logic [2:0]  pwm_wait;
		logic        blink_on, blink_phase_on, fade_on, fade_falling, stop_armed;
		logic [15:0] blink_wait, fade_wait, stop_wait;
		logic [7:0]  end_level;
		led_result_t led_expected_q[$];
		int          mismatches;

		function new();
			regs = '0;
			regs.blink_on_ticks = 16'd1;
			regs.blink_off_ticks = 16'd1;
			regs.fade_step_ticks = 16'd1;
			dim_level = '0;
			pin = 1'b0;
			pwm_wait = '0;
			blink_on = 1'b0;
			blink_phase_on = 1'b0;
			fade_on = 1'b0;
			fade_falling = 1'b0;
			stop_armed = 1'b0;
			blink_wait = '0;
			fade_wait = '0;
			stop_wait = '0;
			end_level = '0;
			mismatches = 0;
		endfunction

		function void set_reg(lpbf_pkg::reg_idx_t idx, logic [31:0] val);
			case (idx)
				lpbf_pkg::REG_BLINK_ON_LEVEL:  regs.blink_on_level = val[7:0];
				lpbf_pkg::REG_BLINK_OFF_LEVEL: regs.blink_off_level = val[7:0];
				lpbf_pkg::REG_BLINK_ON_TICKS:  regs.blink_on_ticks = val[15:0];
				lpbf_pkg::REG_BLINK_OFF_TICKS: regs.blink_off_ticks = val[15:0];
				lpbf_pkg::REG_FADE_STEP_TICKS: regs.fade_step_ticks = val[15:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return led_expected_q.size();
		endfunction

		// true when the timer runs out on this tick; otherwise counts down
		function bit timer_expired(inout logic [15:0] w);
			if (w <= 16'd1)
				return 1'b1;
			w = w - 16'd1;
			return 1'b0;
		endfunction

		function void stop_all();
			stop_armed = 1'b0;
			blink_on = 1'b0;
			fade_on = 1'b0;
			dim_level = end_level[7:5];
		endfunction

		// common start of blink and fade: stop, then load the end brightness
		function void start_effect(lpbf_pkg::item_t it);
			logic [2:0] prior_level;
			prior_level = dim_level;
			stop_all();
			end_level = it.restore_end ? {prior_level, 5'b0} : it.end_brightness;
			if (!it.endless) begin
				stop_armed = 1'b1;
				stop_wait = it.duration;
			end
		endfunction

		// one time step: auto stop, then blink / fade timer, then PWM
		function void advance_tick();
			if (stop_armed && timer_expired(stop_wait))
				stop_all();
			if (blink_on && timer_expired(blink_wait)) begin
				blink_phase_on = ~blink_phase_on;
				if (blink_phase_on) begin
					dim_level = regs.blink_on_level[7:5];
					blink_wait = regs.blink_on_ticks;
				end else begin
					dim_level = regs.blink_off_level[7:5];
					blink_wait = regs.blink_off_ticks;
				end
			end
			if (fade_on && timer_expired(fade_wait)) begin
				dim_level = fade_falling ? dim_level - 3'd1 : dim_level + 3'd1;
				if (dim_level == LEVEL_MAX)
					fade_falling = 1'b1;
				else if (dim_level == 3'd0)
					fade_falling = 1'b0;
				fade_wait = regs.fade_step_ticks;
			end
			if (pwm_wait <= 3'd1) begin
				if (dim_level == 3'd0) begin
					pin = 1'b0;
					pwm_wait = LEVEL_MAX;
				end else if (dim_level == LEVEL_MAX) begin
					pin = 1'b1;
					pwm_wait = LEVEL_MAX;
				end else begin
					pwm_wait = pin ? LEVEL_MAX - dim_level : dim_level;
					pin = ~pin;
				end
			end else begin
				pwm_wait = pwm_wait - 3'd1;
			end
		endfunction

		// note an accepted input item and queue its predicted result
		function void predict_item(lpbf_pkg::item_t it);
			led_result_t r;
			case (lpbf_pkg::action_t'(it.action))
				lpbf_pkg::ACT_TICK:    advance_tick();
				lpbf_pkg::ACT_SET:     dim_level = it.brightness[7:5];
				lpbf_pkg::ACT_STEP_UP: dim_level = dim_level + 3'd1;
				lpbf_pkg::ACT_STEP_DN: dim_level = dim_level - 3'd1;
				lpbf_pkg::ACT_BLINK: begin
					start_effect(it);
					blink_on = 1'b1;
					blink_phase_on = 1'b0;
					dim_level = regs.blink_off_level[7:5];
					blink_wait = regs.blink_off_ticks;
				end
				lpbf_pkg::ACT_FADE: begin
					start_effect(it);
					fade_on = 1'b1;
					fade_falling = 1'b0;
					dim_level = 3'd0;
					fade_wait = regs.fade_step_ticks;
				end
				lpbf_pkg::ACT_STOP:    stop_all();
				default: ;
			endcase
			r.led_on = pin;
			r.level = dim_level;
			r.mode = blink_on ? lpbf_pkg::MODE_BLINK
				: (fade_on ? lpbf_pkg::MODE_FADE : lpbf_pkg::MODE_STEADY);
			led_expected_q.push_back(r);
		endfunction

		// compare an accepted result with the oldest prediction
		function void check_led_result(logic led_on, logic [2:0] level, logic [1:0] mode);
			led_result_t e;
			if (led_expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result led_on=%0b level=%0d mode=%0d",
						$realtime, led_on, level, mode);
				return;
			end
			e = led_expected_q.pop_front();
			if (led_on !== e.led_on || level !== e.level || mode !== e.mode) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: mismatch exp led_on=%0b level=%0d mode=%0d, got %0b %0d %0d",
						$realtime, e.led_on, e.level, e.mode, led_on, level, mode);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  action;
	logic [7:0]  brightness;
	logic [7:0]  end_brightness;
	logic        restore_end;
	logic        endless;
	logic [15:0] duration;
	logic        out_valid;
	logic        out_stall;
	logic        led_on;
	logic [2:0]  level;
	logic [1:0]  mode;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [lpbf_pkg::ADDR_BITS-1:0] paddr;
	logic [lpbf_pkg::DATA_BITS-1:0] pwdata;
	logic [lpbf_pkg::DATA_BITS-1:0] prdata;
	logic        pready;

	dimmer_scoreboard sb;
	bit quiet_tail;   // no idling on either side
	bit send_bursty;  // sender gaps enabled in this stretch

	led_pwm_blink_fade_controller_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .brightness(brightness), .end_brightness(end_brightness),
		.restore_end(restore_end), .endless(endless), .duration(duration),
		.out_valid(out_valid), .out_stall(out_stall),
		.led_on(led_on), .level(level), .mode(mode),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// Transfer monitor: inputs feed the predictor, results are checked
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.predict_item('{action, brightness, end_brightness, restore_end,
					endless, duration});
			if (out_valid && !out_stall)
				sb.check_led_result(led_on, level, mode);
		end
	end

	// Receiver stalls in random bursts
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	function automatic lpbf_pkg::item_t make_item(lpbf_pkg::action_t act, logic [7:0] bright,
			logic [7:0] end_b, logic keep, logic forever_on, logic [15:0] dur);
		lpbf_pkg::item_t it;
		it.action = act;
		it.brightness = bright;
		it.end_brightness = end_b;
		it.restore_end = keep;
		it.endless = forever_on;
		it.duration = dur;
		return it;
	endfunction

	// Mostly ticks so timers run out; commands with random content between
	function automatic lpbf_pkg::item_t random_item();
		lpbf_pkg::item_t it;
		it.action = ($urandom_range(0, 99) < 55) ? lpbf_pkg::ACT_TICK
			: lpbf_pkg::action_t'($urandom_range(1, 6));
		it.brightness = 8'($urandom_range(0, 255));
		it.end_brightness = 8'($urandom_range(0, 255));
		it.restore_end = 1'($urandom_range(0, 1));
		it.endless = ($urandom_range(0, 3) == 0);
		it.duration = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(1, 60))
			: 16'($urandom_range(1, 65535));
		return it;
	endfunction

	// Present one item, hold until transfer, then maybe idle
	task automatic send_item(lpbf_pkg::item_t it);
		action <= it.action;
		brightness <= it.brightness;
		end_brightness <= it.end_brightness;
		restore_end <= it.restore_end;
		endless <= it.endless;
		duration <= it.duration;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (!quiet_tail && send_bursty && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	// Stop sending and wait until every predicted result has arrived
	task automatic drain();
		in_valid <= 1'b0;
		// let the monitor note the last transfer before counting
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// APB write: setup cycle, access cycle
	task automatic write_reg(lpbf_pkg::reg_idx_t idx, logic [31:0] val);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_reg(idx, val);
	endtask

	task automatic write_all(logic [7:0] on_lvl, logic [7:0] off_lvl, logic [15:0] on_t,
			logic [15:0] off_t, logic [15:0] fade_t);
		write_reg(lpbf_pkg::REG_BLINK_ON_LEVEL, 32'(on_lvl));
		write_reg(lpbf_pkg::REG_BLINK_OFF_LEVEL, 32'(off_lvl));
		write_reg(lpbf_pkg::REG_BLINK_ON_TICKS, 32'(on_t));
		write_reg(lpbf_pkg::REG_BLINK_OFF_TICKS, 32'(off_t));
		write_reg(lpbf_pkg::REG_FADE_STEP_TICKS, 32'(fade_t));
	endtask

	task automatic send_ticks(int n);
		repeat (n) send_item(make_item(lpbf_pkg::ACT_TICK, 8'h00, 8'h00, 1'b0, 1'b0, 16'd1));
	endtask

	initial begin
		int max_tick;
		sb = new();
		quiet_tail = 1'b0;
		send_bursty = 1'b1;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		action <= lpbf_pkg::ACT_TICK;
		brightness <= '0;
		end_brightness <= '0;
		restore_end <= 1'b0;
		endless <= 1'b0;
		duration <= 16'd1;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: level extremes, wrap both ways, every command
		write_all(8'hE0, 8'h20, 16'd2, 16'd3, 16'd1);
		send_ticks(2);
		send_item(make_item(lpbf_pkg::ACT_SET, 8'hFF, 8'h00, 1'b0, 1'b0, 16'd1));
		send_ticks(2);
		send_item(make_item(lpbf_pkg::ACT_SET, 8'h00, 8'h00, 1'b0, 1'b0, 16'd1));
		send_item(make_item(lpbf_pkg::ACT_STEP_DN, 8'h00, 8'h00, 1'b0, 1'b0, 16'd1));
		send_item(make_item(lpbf_pkg::ACT_STEP_UP, 8'h00, 8'h00, 1'b0, 1'b0, 16'd1));
		// stop while steady still restores the end level
		send_item(make_item(lpbf_pkg::ACT_STOP, 8'h00, 8'h00, 1'b0, 1'b0, 16'd1));
		send_item(make_item(lpbf_pkg::ACT_SET, 8'h9F, 8'h00, 1'b0, 1'b0, 16'd1));
		// endless blink keeping the prior level as end brightness
		send_item(make_item(lpbf_pkg::ACT_BLINK, 8'h00, 8'h00, 1'b1, 1'b1, 16'd1));
		send_ticks(4);
		send_item(make_item(lpbf_pkg::ACT_STEP_UP, 8'h00, 8'h00, 1'b0, 1'b0, 16'd1));
		// fade with a short duration restores the given end brightness
		send_item(make_item(lpbf_pkg::ACT_FADE, 8'h00, 8'hFF, 1'b0, 1'b0, 16'd3));
		send_ticks(4);
		send_item(make_item(lpbf_pkg::ACT_FADE, 8'hFF, 8'h00, 1'b1, 1'b0, 16'hFFFF));
		send_ticks(3);
		send_item(make_item(lpbf_pkg::ACT_STOP, 8'h00, 8'h00, 1'b0, 1'b0, 16'd1));
		drain();

		// Random phases over several register settings
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: write_all(8'hFF, 8'h00, 16'd1, 16'd1, 16'd1);
				2: write_all(8'h00, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
				default: begin
					max_tick = (phase == 1) ? 9 : (phase == 3) ? 5 : 16;
					write_all(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
						16'($urandom_range(1, max_tick)), 16'($urandom_range(1, max_tick)),
						16'($urandom_range(1, max_tick)));
				end
			endcase
			for (int i = 0; i < 230; i++) begin
				if (i % 40 == 0)
					send_bursty = $urandom_range(0, 1);
				if (phase == 4 && i == 115)
					quiet_tail = 1'b1;
				// sender holds off until the pipeline is empty
				if (phase == 1 && i == 100)
					drain();
				send_item(random_item());
			end
			drain();
		end

		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

/* filelist.f */
sv/lpbf_pkg.sv
sv/lpbf_regs.sv
sv/lpbf_core.sv
sv/led_pwm_blink_fade_controller_top.sv
sv/lpbf_checker.sv
sim/led_pwm_blink_fade_controller_top_tb.sv
